// File: rtl/plit_pkg.sv
package plit_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;
  localparam int   CMD_QUERY_BIT = 1;

  typedef enum logic [1:0] {
    ST_ANSWERED = 2'd0,
    ST_STORED   = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_Q_FIRST,
    S_Q_WALK,
    S_MAG,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_V0,
    RES_RDV,
    RES_LERP
  } res_sel_t;

  typedef struct packed {
    logic      latch_in;
    logic      append;
    logic      clear;
    logic      idx_clr;
    logic      idx_inc;
    logic      k0_load;
    logic      diff_load;
    logic      mag_load;
    logic      mul_load;
    logic      div_step;
    logic      res_load;
    res_sel_t  res_sel;
    status_t   res_status;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_append;
    logic full;
    logic empty;
    logic one_entry;
    logic last;
    logic bracket;
    logic key_eq;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/plit_ifs.sv
interface plit_in_if;
  import plit_pkg::*;

  logic                     valid;
  logic                     ready;
  cmd_t                     command;
  logic signed [DATA_W-1:0] key_in;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, output command, output key_in, output value_in, input ready);
  modport sink (input valid, input command, input key_in, input value_in, output ready);
  modport monitor (input valid, input command, input key_in, input value_in, input ready);
endinterface

interface plit_out_if;
  import plit_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  status_t                  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
  modport monitor (input valid, input result_value, input status, input ready);
endinterface

// File: rtl/plit_ctrl.sv
module plit_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plit_pkg::dp_stat_t stat,
  output plit_pkg::dp_cmd_t  cmd
);
  import plit_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_query && !stat.empty) state_nxt = S_Q_FIRST;
        else state_nxt = S_DONE;
      end
      S_Q_FIRST: begin
        if (stat.one_entry) state_nxt = S_DONE;
        else state_nxt = S_Q_WALK;
      end
      S_Q_WALK: begin
        if (stat.bracket) state_nxt = S_MAG;
        else if (stat.key_eq || stat.last) state_nxt = S_DONE;
      end
      S_MAG:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV: begin
        if (stat.div_last) state_nxt = S_FIN;
      end
      S_FIN:  state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_sel    = RES_ZERO;
    cmd.res_status = ST_ANSWERED;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_EXEC: begin
        cmd.res_load = 1'b1;
        if (stat.is_query) begin
          cmd.idx_clr = 1'b1;
        end else if (stat.is_append) begin
          cmd.append     = 1'b1;
          cmd.res_status = stat.full ? ST_DROPPED : ST_STORED;
        end else begin
          cmd.clear      = 1'b1;
          cmd.res_status = ST_CLEARED;
        end
      end
      S_Q_FIRST: begin
        cmd.k0_load = 1'b1;
        if (stat.one_entry) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RDV;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_Q_WALK: begin
        if (stat.bracket) begin
          cmd.diff_load = 1'b1;
        end else if (stat.key_eq) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_V0;
        end else if (stat.last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RDV;
        end else begin
          cmd.k0_load = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_MAG: cmd.mag_load = 1'b1;
      S_MUL: cmd.mul_load = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_FIN: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_LERP;
      end
      S_DONE: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/plit_dp.sv
module plit_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  plit_pkg::dp_cmd_t                  cmd,
  output plit_pkg::dp_stat_t                 stat,
  input  plit_pkg::cmd_t                     in_command,
  input  logic signed [plit_pkg::DATA_W-1:0] in_key,
  input  logic signed [plit_pkg::DATA_W-1:0] in_value,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [plit_pkg::DATA_W-1:0] out_result,
  output plit_pkg::status_t                  out_status
);
  import plit_pkg::*;

  logic signed [DATA_W-1:0] key_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] val_mem [TABLE_DEPTH];

  cmd_t                     cmd_r;
  logic signed [DATA_W-1:0] x_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         count_r;
  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         idx_nxt;
  logic signed [DATA_W-1:0] rdk_r;
  logic signed [DATA_W-1:0] rdv_r;
  logic signed [DATA_W-1:0] k0_r;
  logic signed [DATA_W-1:0] v0_r;
  logic signed [DIFF_W-1:0] dv_r;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dk_r;
  logic [DATA_W-1:0]        mdv_r;
  logic [DATA_W-1:0]        mdx_r;
  logic [DATA_W-1:0]        mdk_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        prod;
  logic [DATA_W-1:0]        rem_r;
  logic [DATA_W-1:0]        lo_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic [DIFF_W-1:0]        trial;
  logic [DIFF_W-1:0]        trial_sub;
  logic                     trial_ge;
  logic signed [DATA_W-1:0] res_r;
  logic signed [DATA_W-1:0] res_nxt;
  status_t                  st_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_result_r;
  status_t                  out_status_r;
  logic                     full;

  assign full = (count_r == CNT_W'(TABLE_DEPTH));

  always_comb begin
    if (cmd.idx_clr) idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + 1'b1;
    else idx_nxt = idx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      key_mem[count_r[IDX_W-1:0]] <= x_r;
      val_mem[count_r[IDX_W-1:0]] <= val_r;
    end
    rdk_r <= key_mem[idx_nxt];
    rdv_r <= val_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.clear) count_r <= '0;
      else if (cmd.append && !full) count_r <= count_r + 1'b1;
      if (cmd.mul_load) dcnt_r <= '0;
      else if (cmd.div_step) dcnt_r <= dcnt_r + 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // magnitudes of the differences, then product, then restoring division
  assign prod      = PROD_W'(mdv_r) * PROD_W'(mdx_r);
  assign trial     = {rem_r, lo_r[DATA_W-1]};
  assign trial_ge  = (trial >= {1'b0, mdk_r});
  assign trial_sub = trial - {1'b0, mdk_r};

  always_comb begin
    case (cmd.res_sel)
      RES_ZERO: res_nxt = '0;
      RES_V0:   res_nxt = v0_r;
      RES_RDV:  res_nxt = rdv_r;
      RES_LERP: res_nxt = neg_r ? (v0_r - $signed(lo_r)) : (v0_r + $signed(lo_r));
      default:  res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_command;
      x_r   <= in_key;
      val_r <= in_value;
    end
    if (cmd.k0_load) begin
      k0_r <= rdk_r;
      v0_r <= rdv_r;
    end
    if (cmd.diff_load) begin
      dv_r <= DIFF_W'(rdv_r) - DIFF_W'(v0_r);
      dx_r <= DIFF_W'(x_r) - DIFF_W'(k0_r);
      dk_r <= DIFF_W'(rdk_r) - DIFF_W'(k0_r);
    end
    if (cmd.mag_load) begin
      mdv_r <= dv_r[DIFF_W-1] ? DATA_W'(-dv_r) : dv_r[DATA_W-1:0];
      mdx_r <= dx_r[DIFF_W-1] ? DATA_W'(-dx_r) : dx_r[DATA_W-1:0];
      mdk_r <= dk_r[DIFF_W-1] ? DATA_W'(-dk_r) : dk_r[DATA_W-1:0];
      neg_r <= dv_r[DIFF_W-1] ^ dx_r[DIFF_W-1] ^ dk_r[DIFF_W-1];
    end
    if (cmd.mul_load) begin
      rem_r <= prod[PROD_W-1:DATA_W];
      lo_r  <= prod[DATA_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      lo_r  <= {lo_r[DATA_W-2:0], trial_ge};
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
      st_r  <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_result_r <= res_r;
      out_status_r <= st_r;
    end
  end

  assign stat.is_query  = cmd_r[CMD_QUERY_BIT];
  assign stat.is_append = (cmd_r == CMD_APPEND);
  assign stat.full      = full;
  assign stat.empty     = (count_r == '0);
  assign stat.one_entry = (count_r == CNT_W'(1));
  assign stat.last      = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign stat.bracket   = ((k0_r > x_r) && (rdk_r < x_r)) || ((k0_r < x_r) && (rdk_r > x_r));
  assign stat.key_eq    = (k0_r == x_r);
  assign stat.div_last  = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

endmodule

// File: rtl/piecewise_linear_table_interp.sv
// channel   direction  payload                              transaction when
// in_ch     sink       command, key_in, value_in            valid && ready
// out_ch    source     result_value, status                 valid && ready
//
// one transaction at a time; ready is high only between transactions
// clear and append: after acceptance, the execute and done states pass before the next acceptance
// query: breakpoints are walked in order (up to the table depth); when a bracketing pair
//   is found, magnitudes, product and the bit-serial divider run before the result step
// result waits in an output register, so a stalled sink holds back only the next result
// reset (rst_n low, synchronous) empties the table; breakpoint memories are not cleared
module piecewise_linear_table_interp (
  input  logic        clk,
  input  logic        rst_n,
  plit_in_if.sink     in_ch,
  plit_out_if.source  out_ch
);
  import plit_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  plit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plit_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (in_ch.command),
    .in_key     (in_ch.key_in),
    .in_value   (in_ch.value_in),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_result (out_ch.result_value),
    .out_status (out_ch.status)
  );

endmodule

// File: rtl/plit_checker.sv
module plit_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [plit_pkg::DATA_W-1:0] out_result_value,
  input plit_pkg::status_t                  out_status
);
  import plit_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_result_value) && $stable(out_status))
    else $error("result changed while stalled");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ANSWERED |-> out_result_value == '0)
    else $error("non-query result carries a value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind piecewise_linear_table_interp plit_checker u_plit_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.result_value),
  .out_status       (out_ch.status)
);
